// File: rtl/core/bwr_pkg.sv
`timescale 1ns / 1ps

package bwr_pkg;

	// Fixed shape of one texel word.
	localparam int unsigned LAYER_COUNT = 8;
	localparam int unsigned WEIGHT_W    = 8;
	localparam int unsigned SEL_W       = 4;
	localparam int unsigned LAYER_IDX_W = $clog2(LAYER_COUNT);

	// Sum of all other layers, product of a weight and the remainder, and quotient.
	localparam int unsigned SUM_W  = WEIGHT_W + $clog2(LAYER_COUNT);
	localparam int unsigned PROD_W = 2 * WEIGHT_W;
	localparam int unsigned QUOT_W = WEIGHT_W;

	// Full scale that the weights of one texel add up to.
	localparam logic [WEIGHT_W-1:0] FULL_WEIGHT = '1;

	typedef logic [WEIGHT_W-1:0]                   weight_t;
	typedef logic [LAYER_COUNT-1:0][WEIGHT_W-1:0]  weight_vec_t;
	typedef logic [LAYER_COUNT-1:0][PROD_W-1:0]    prod_vec_t;
	typedef logic [SUM_W-1:0]                      sum_t;

	// Input word as it enters the pipeline.
	typedef struct packed {
		weight_vec_t       weight;
		logic [SEL_W-1:0]  chosen_layer;
		weight_t           target_weight;
	} texel_t;

	// Per-texel control that rides along with the lanes.
	typedef struct packed {
		logic [LAYER_IDX_W-1:0] chosen;
		logic                   applied;
		logic                   others_zero;
	} ctl_t;

	// Word inside the divider: partial remainders and quotient bits per lane.
	typedef struct packed {
		ctl_t        ctl;
		weight_vec_t orig;
		sum_t        divisor;
		prod_vec_t   rem;
		weight_vec_t quot;
	} div_word_t;

	// Finished result word.
	typedef struct packed {
		weight_vec_t weight;
		logic        applied;
	} result_t;

endpackage

// File: rtl/core/bwr_in_if.sv
`timescale 1ns / 1ps

interface bwr_in_if;

	logic                        valid;
	logic                        ready;
	logic [bwr_pkg::WEIGHT_W-1:0] weight_0;
	logic [bwr_pkg::WEIGHT_W-1:0] weight_1;
	logic [bwr_pkg::WEIGHT_W-1:0] weight_2;
	logic [bwr_pkg::WEIGHT_W-1:0] weight_3;
	logic [bwr_pkg::WEIGHT_W-1:0] weight_4;
	logic [bwr_pkg::WEIGHT_W-1:0] weight_5;
	logic [bwr_pkg::WEIGHT_W-1:0] weight_6;
	logic [bwr_pkg::WEIGHT_W-1:0] weight_7;
	logic [bwr_pkg::SEL_W-1:0]    chosen_layer;
	logic [bwr_pkg::WEIGHT_W-1:0] target_weight;

	modport source (
		output valid, weight_0, weight_1, weight_2, weight_3,
			weight_4, weight_5, weight_6, weight_7, chosen_layer, target_weight,
		input  ready
	);

	modport sink (
		input  valid, weight_0, weight_1, weight_2, weight_3,
			weight_4, weight_5, weight_6, weight_7, chosen_layer, target_weight,
		output ready
	);

endinterface

// File: rtl/core/bwr_out_if.sv
`timescale 1ns / 1ps

interface bwr_out_if;

	logic                        valid;
	logic                        ready;
	logic [bwr_pkg::WEIGHT_W-1:0] new_weight_0;
	logic [bwr_pkg::WEIGHT_W-1:0] new_weight_1;
	logic [bwr_pkg::WEIGHT_W-1:0] new_weight_2;
	logic [bwr_pkg::WEIGHT_W-1:0] new_weight_3;
	logic [bwr_pkg::WEIGHT_W-1:0] new_weight_4;
	logic [bwr_pkg::WEIGHT_W-1:0] new_weight_5;
	logic [bwr_pkg::WEIGHT_W-1:0] new_weight_6;
	logic [bwr_pkg::WEIGHT_W-1:0] new_weight_7;
	logic                        applied;

	modport source (
		output valid, new_weight_0, new_weight_1, new_weight_2, new_weight_3,
			new_weight_4, new_weight_5, new_weight_6, new_weight_7, applied,
		input  ready
	);

	modport sink (
		input  valid, new_weight_0, new_weight_1, new_weight_2, new_weight_3,
			new_weight_4, new_weight_5, new_weight_6, new_weight_7, applied,
		output ready
	);

endinterface

// File: rtl/core/bwr_prep.sv
`timescale 1ns / 1ps

// First stage: checks the layer index, sums the other layers and forms the
// dividends weight * (255 - target) for every lane, with the chosen lane's weight taken as zero.
module bwr_prep (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                up_valid,
	output logic                up_ready,
	input  bwr_pkg::texel_t     up_word,
	output logic                dn_valid,
	input  logic                dn_ready,
	output bwr_pkg::div_word_t  dn_word
);
	import bwr_pkg::*;

	logic      valid_s1;
	div_word_t word_s1;
	div_word_t word_next;

	// Lane products and the sum of the other layers.
	always_comb begin
		logic [LAYER_IDX_W-1:0] idx;
		weight_t                rem_w;
		weight_t                masked;
		sum_t                   others;
		idx    = up_word.chosen_layer[LAYER_IDX_W-1:0];
		rem_w  = FULL_WEIGHT - up_word.target_weight;
		others = '0;
		word_next.orig = up_word.weight;
		word_next.quot = '0;
		for (int l = 0; l < LAYER_COUNT; l++) begin
			masked = (LAYER_IDX_W'(l) == idx) ? '0 : up_word.weight[l];
			others = others + SUM_W'(masked);
			word_next.rem[l] = PROD_W'(masked) * PROD_W'(rem_w);
		end
		word_next.divisor         = others;
		word_next.ctl.chosen      = idx;
		word_next.ctl.applied     = (up_word.chosen_layer < SEL_W'(LAYER_COUNT));
		word_next.ctl.others_zero = (others == '0);
	end

	// The stage takes a word when it is empty or its word moves on.
	assign up_ready = !valid_s1 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			word_s1 <= word_next;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_word  = word_s1;

endmodule

// File: rtl/core/bwr_divider.sv
`timescale 1ns / 1ps

// Restoring divider for all lanes at once: the quotient has eight bits and
// every stage settles two of them, most significant first.
module bwr_divider (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                up_valid,
	output logic                up_ready,
	input  bwr_pkg::div_word_t  up_word,
	output logic                dn_valid,
	input  logic                dn_ready,
	output bwr_pkg::div_word_t  dn_word
);
	import bwr_pkg::*;

	localparam int unsigned BITS_PER_STAGE = 2;
	localparam int unsigned CMP_W          = SUM_W + QUOT_W - 1;
	localparam int unsigned QBIT_W         = $clog2(QUOT_W);

	// Settles quotient bits top_bit down to top_bit - BITS_PER_STAGE + 1.
	function automatic div_word_t div_step(div_word_t d, logic [QBIT_W-1:0] top_bit);
		div_word_t         n;
		logic [CMP_W-1:0]  shifted;
		logic [QBIT_W-1:0] j;
		n = d;
		for (int l = 0; l < LAYER_COUNT; l++) begin
			for (int k = 0; k < BITS_PER_STAGE; k++) begin
				j       = top_bit - QBIT_W'(k);
				shifted = CMP_W'(d.divisor) << j;
				if (CMP_W'(n.rem[l]) >= shifted) begin
					n.rem[l]     = n.rem[l] - PROD_W'(shifted);
					n.quot[l][j] = 1'b1;
				end
			end
		end
		return n;
	endfunction

	logic      valid_s2, valid_s3, valid_s4, valid_s5;
	div_word_t word_s2, word_s3, word_s4, word_s5;
	logic      ready_s2, ready_s3, ready_s4, ready_s5;

	// Each stage takes a word when it is empty or its own word moves on.
	assign ready_s5 = !valid_s5 || dn_ready;
	assign ready_s4 = !valid_s4 || ready_s5;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign up_ready = ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (ready_s2) valid_s2 <= up_valid;
			if (ready_s3) valid_s3 <= valid_s2;
			if (ready_s4) valid_s4 <= valid_s3;
			if (ready_s5) valid_s5 <= valid_s4;
		end
	end

	// Quotient bits 7..6, 5..4, 3..2 and 1..0.
	always_ff @(posedge clk) begin
		if (ready_s2 && up_valid) begin
			word_s2 <= div_step(up_word, QBIT_W'(QUOT_W - 1));
		end
		if (ready_s3 && valid_s2) begin
			word_s3 <= div_step(word_s2, QBIT_W'(QUOT_W - 1 - BITS_PER_STAGE));
		end
		if (ready_s4 && valid_s3) begin
			word_s4 <= div_step(word_s3, QBIT_W'(QUOT_W - 1 - 2 * BITS_PER_STAGE));
		end
		if (ready_s5 && valid_s4) begin
			word_s5 <= div_step(word_s4, QBIT_W'(QUOT_W - 1 - 3 * BITS_PER_STAGE));
		end
	end

	assign dn_valid = valid_s5;
	assign dn_word  = word_s5;

endmodule

// File: rtl/core/bwr_merge.sv
`timescale 1ns / 1ps

// Last stage: adds up the shares, gives the chosen layer the rest of the
// full weight and picks pass-through or the all-zero case.
module bwr_merge (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                up_valid,
	output logic                up_ready,
	input  bwr_pkg::div_word_t  up_word,
	output logic                dn_valid,
	input  logic                dn_ready,
	output bwr_pkg::result_t    dn_word
);
	import bwr_pkg::*;

	logic    valid_s6;
	result_t result_s6;
	result_t result_next;

	always_comb begin
		sum_t    given;
		weight_t chosen_w;
		logic    is_ch;
		given = '0;
		for (int l = 0; l < LAYER_COUNT; l++) begin
			given = given + SUM_W'(up_word.quot[l]);
		end
		// The chosen lane has a zero dividend, so it adds nothing to the total.
		chosen_w = FULL_WEIGHT - given[WEIGHT_W-1:0];
		for (int l = 0; l < LAYER_COUNT; l++) begin
			is_ch = (LAYER_IDX_W'(l) == up_word.ctl.chosen);
			if (!up_word.ctl.applied) begin
				result_next.weight[l] = up_word.orig[l];
			end else if (up_word.ctl.others_zero) begin
				result_next.weight[l] = is_ch ? FULL_WEIGHT : '0;
			end else begin
				result_next.weight[l] = is_ch ? chosen_w : up_word.quot[l];
			end
		end
		result_next.applied = up_word.ctl.applied;
	end

	// Output register: holds its word until the consumer takes it.
	assign up_ready = !valid_s6 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else if (up_ready) begin
			valid_s6 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			result_s6 <= result_next;
		end
	end

	assign dn_valid = valid_s6;
	assign dn_word  = result_s6;

endmodule

// File: rtl/core/blend_weight_renormalizer_top.sv
`timescale 1ns / 1ps

// Channel   Modport  Word
// texel     sink     weight_0..weight_7, chosen_layer, target_weight
// renorm    source   new_weight_0..new_weight_7, applied
//
// One word is taken per cycle while renorm is not stalled. A result is offered
// on renorm after its word has passed six registers: one stage for the sums and
// products, four divider stages at two quotient bits each, and the output
// register.
// Reset clears only the valid bits of the six stages.
// A stalled output holds its word; each stage still fills while it is empty,
// so bubbles close up before texel.ready drops.
module blend_weight_renormalizer_top (
	input  logic      clk,
	input  logic      arst_n,
	bwr_in_if.sink    texel,
	bwr_out_if.source renorm
);
	import bwr_pkg::*;

	texel_t    texel_word;
	logic      prep_valid, prep_ready;
	div_word_t prep_word;
	logic      div_valid, div_ready;
	div_word_t div_word;
	result_t   result_word;

	// Gather the input word.
	assign texel_word.weight[0]     = texel.weight_0;
	assign texel_word.weight[1]     = texel.weight_1;
	assign texel_word.weight[2]     = texel.weight_2;
	assign texel_word.weight[3]     = texel.weight_3;
	assign texel_word.weight[4]     = texel.weight_4;
	assign texel_word.weight[5]     = texel.weight_5;
	assign texel_word.weight[6]     = texel.weight_6;
	assign texel_word.weight[7]     = texel.weight_7;
	assign texel_word.chosen_layer  = texel.chosen_layer;
	assign texel_word.target_weight = texel.target_weight;

	bwr_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (texel.valid),
		.up_ready (texel.ready),
		.up_word  (texel_word),
		.dn_valid (prep_valid),
		.dn_ready (prep_ready),
		.dn_word  (prep_word)
	);

	bwr_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (prep_valid),
		.up_ready (prep_ready),
		.up_word  (prep_word),
		.dn_valid (div_valid),
		.dn_ready (div_ready),
		.dn_word  (div_word)
	);

	bwr_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (div_valid),
		.up_ready (div_ready),
		.up_word  (div_word),
		.dn_valid (renorm.valid),
		.dn_ready (renorm.ready),
		.dn_word  (result_word)
	);

	// Spread the result word over the output fields.
	assign renorm.new_weight_0 = result_word.weight[0];
	assign renorm.new_weight_1 = result_word.weight[1];
	assign renorm.new_weight_2 = result_word.weight[2];
	assign renorm.new_weight_3 = result_word.weight[3];
	assign renorm.new_weight_4 = result_word.weight[4];
	assign renorm.new_weight_5 = result_word.weight[5];
	assign renorm.new_weight_6 = result_word.weight[6];
	assign renorm.new_weight_7 = result_word.weight[7];
	assign renorm.applied      = result_word.applied;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

	import bwr_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 100000;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned DRAIN_CYCLES = 12;
	localparam int unsigned IDLE_PCT     = 34;
	localparam int unsigned RANDOM_WORDS = 1036;

	// Keeps the renormalized words still owed by the block, oldest first.
	class renorm_scoreboard;
		result_t     owed_q[$];
		int unsigned mismatches;

		function new();
			mismatches = 0;
		endfunction

		// Shares the remainder among the other layers by floor division.
		function result_t renormalize(texel_t t);
			result_t     r;
			int unsigned remainder;
			int unsigned others;
			int unsigned given;
			int unsigned share;
			r.weight  = t.weight;
			r.applied = 1'b0;
			if (t.chosen_layer >= LAYER_COUNT) begin
				return r;
			end
			remainder = int'(FULL_WEIGHT) - int'(t.target_weight);
			others    = 0;
			given     = 0;
			for (int i = 0; i < LAYER_COUNT; i++) begin
				if (i != t.chosen_layer)
					others += t.weight[i];
			end
			if (others > 0) begin
				for (int i = 0; i < LAYER_COUNT; i++) begin
					if (i != t.chosen_layer) begin
						share       = (t.weight[i] * remainder) / others;
						r.weight[i] = share[WEIGHT_W-1:0];
						given      += share;
					end
				end
				r.weight[t.chosen_layer] = weight_t'(int'(FULL_WEIGHT) - given);
			end else begin
				r.weight                 = '0;
				r.weight[t.chosen_layer] = FULL_WEIGHT;
			end
			r.applied = 1'b1;
			return r;
		endfunction

		function void note_texel(texel_t t);
			owed_q.insert(owed_q.size(), renormalize(t));
		endfunction

		function void check_word(result_t got);
			result_t want;
			if (owed_q.size() == 0) begin
				$error("renorm word arrived with no texel outstanding");
				mismatches++;
				return;
			end
			want = owed_q.pop_front();
			for (int i = 0; i < LAYER_COUNT; i++) begin
				if (got.weight[i] !== want.weight[i]) begin
					$error("new_weight_%0d: expected %0d, actual %0d", i,
						want.weight[i], got.weight[i]);
					mismatches++;
				end
			end
			if (got.applied !== want.applied) begin
				$error("applied: expected %0d, actual %0d", want.applied, got.applied);
				mismatches++;
			end
		endfunction

		function int unsigned pending();
			return owed_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	bwr_in_if  texel();
	bwr_out_if renorm();

	blend_weight_renormalizer_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.texel  (texel),
		.renorm (renorm)
	);

	renorm_scoreboard sb = new();

	// Set by the stimulus: no idling on either side, and a request for a long stall.
	bit          steady   = 1'b0;
	bit          hold_req = 1'b0;
	int unsigned cycle_count = 0;

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Observe both channels at the clock edge.
	always @(posedge clk) begin
		texel_t  t;
		result_t r;
		if (arst_n && texel.valid && texel.ready) begin
			t.weight = {texel.weight_7, texel.weight_6, texel.weight_5, texel.weight_4,
				texel.weight_3, texel.weight_2, texel.weight_1, texel.weight_0};
			t.chosen_layer  = texel.chosen_layer;
			t.target_weight = texel.target_weight;
			sb.note_texel(t);
		end
		if (arst_n && renorm.valid && renorm.ready) begin
			r.weight = {renorm.new_weight_7, renorm.new_weight_6, renorm.new_weight_5,
				renorm.new_weight_4, renorm.new_weight_3, renorm.new_weight_2,
				renorm.new_weight_1, renorm.new_weight_0};
			r.applied = renorm.applied;
			sb.check_word(r);
		end
	end

	// Receiver: random stalls, none while steady, and one long stall on request.
	initial begin
		renorm.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				renorm.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
			end else begin
				renorm.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// Offers one word and returns at the edge where it is taken.
	task automatic send_texel(input texel_t t);
		if (!steady && $urandom_range(99) < IDLE_PCT) begin
			texel.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
		end
		texel.valid         <= 1'b1;
		texel.weight_0      <= t.weight[0];
		texel.weight_1      <= t.weight[1];
		texel.weight_2      <= t.weight[2];
		texel.weight_3      <= t.weight[3];
		texel.weight_4      <= t.weight[4];
		texel.weight_5      <= t.weight[5];
		texel.weight_6      <= t.weight[6];
		texel.weight_7      <= t.weight[7];
		texel.chosen_layer  <= t.chosen_layer;
		texel.target_weight <= t.target_weight;
		do @(posedge clk); while (!texel.ready);
	endtask

	task automatic send_fields(input weight_vec_t w, input logic [SEL_W-1:0] layer,
		input weight_t target);
		texel_t t;
		t.weight        = w;
		t.chosen_layer  = layer;
		t.target_weight = target;
		send_texel(t);
	endtask

	// Mostly valid layers, with sparse, tiny, saturated and all-zero neighbors mixed in.
	function automatic texel_t random_texel();
		texel_t      t;
		int unsigned style;
		int unsigned pick;
		t.chosen_layer = ($urandom_range(99) < 85) ? SEL_W'($urandom_range(LAYER_COUNT - 1))
			: SEL_W'($urandom_range(15, LAYER_COUNT));
		style = $urandom_range(9);
		for (int i = 0; i < LAYER_COUNT; i++) begin
			case (style)
				0: begin
					t.weight[i] = '0;
				end
				1: begin
					t.weight[i] = weight_t'($urandom_range(3));
				end
				2: begin
					t.weight[i] = ($urandom_range(1) != 0) ? FULL_WEIGHT : '0;
				end
				3: begin
					t.weight[i] = ($urandom_range(2) == 0) ? weight_t'($urandom_range(255)) : '0;
				end
				default: begin
					t.weight[i] = weight_t'($urandom_range(255));
				end
			endcase
		end
		// With no neighbors the chosen lane may still carry a stray weight.
		if (style == 0 && t.chosen_layer < LAYER_COUNT)
			t.weight[t.chosen_layer] = weight_t'($urandom_range(255));
		pick = $urandom_range(9);
		if (pick == 0)
			t.target_weight = '0;
		else if (pick == 1)
			t.target_weight = FULL_WEIGHT;
		else
			t.target_weight = weight_t'($urandom_range(255));
		return t;
	endfunction

	// Reset, directed words, random phases, then drain.
	initial begin
		arst_n              = 1'b0;
		texel.valid         <= 1'b0;
		texel.weight_0      <= '0;
		texel.weight_1      <= '0;
		texel.weight_2      <= '0;
		texel.weight_3      <= '0;
		texel.weight_4      <= '0;
		texel.weight_5      <= '0;
		texel.weight_6      <= '0;
		texel.weight_7      <= '0;
		texel.chosen_layer  <= '0;
		texel.target_weight <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// All neighbors zero: chosen layer takes the full weight. Then all weights at full scale.
		send_fields('0, 4'd0, 8'd0);
		send_fields({8{8'hFF}}, 4'd7, 8'd0);
		// Target at full scale leaves nothing to share.
		send_fields({8{8'hFF}}, 4'd3, 8'hFF);
		send_fields({8{8'hFF}}, 4'd0, 8'd128);
		send_fields({8{8'hAA}}, 4'd1, 8'h55);
		send_fields({8{8'h55}}, 4'd2, 8'hAA);
		// Only the chosen lane is nonzero, so its own weight is ignored.
		send_fields({8'd0, 8'd0, 8'd200, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}, 4'd5, 8'd17);
		// Rounding loss lands on the chosen layer.
		send_fields({8'd1, 8'd1, 8'd1, 8'd255, 8'd1, 8'd1, 8'd1, 8'd1}, 4'd4, 8'd3);
		send_fields({8'd8, 8'd7, 8'd6, 8'd5, 8'd4, 8'd3, 8'd2, 8'd1}, 4'd6, 8'd100);
		send_fields({8'd9, 8'd0, 8'd77, 8'd3, 8'd0, 8'd250, 8'd1, 8'd40}, 4'd6, 8'hFF);
		// A single neighbor takes the whole remainder.
		send_fields({8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1}, 4'd7, 8'd0);
		// Invalid layer indexes pass the weights through.
		send_fields({8'd8, 8'd7, 8'd6, 8'd5, 8'd4, 8'd3, 8'd2, 8'd1}, 4'd8, 8'd50);
		send_fields({8{8'hFF}}, 4'd15, 8'd0);
		send_fields({8{8'hAA}}, 4'd12, 8'hFF);
		send_fields('0, 4'd9, 8'h55);

		// Random words with idling on both sides, none while steady, and one long stall.
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n == 400)
				steady = 1'b1;
			if (n == 550)
				hold_req = 1'b1;
			if (n == 750)
				steady = 1'b0;
			send_texel(random_texel());
		end
		texel.valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
